>>> hdl/pixel_luma_brighten_assert.svh
// Assertion macros used by the pixel_luma_brighten RTL.
`ifndef PIXEL_LUMA_BRIGHTEN_ASSERT_SVH
`define PIXEL_LUMA_BRIGHTEN_ASSERT_SVH

// When cond holds at a clock edge, conseq must hold at that same edge.
`define PLB_ASSERT_IMPL(name, cond, conseq) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error("pixel_luma_brighten: assertion failed");

// When cond holds at a clock edge, conseq must hold at the next edge.
`define PLB_ASSERT_NEXT(name, cond, conseq) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error("pixel_luma_brighten: assertion failed");

`endif

>>> hdl/plb_pkg.sv
// Package with the coefficients and stage types of the luma brightness pipeline.
`default_nettype none

package plb_pkg;

  // Q2.10 coefficients, kept signed so they extend cleanly in signed math.
  localparam logic signed [11:0] CoefYR = 12'sd306;
  localparam logic signed [11:0] CoefYG = 12'sd601;
  localparam logic signed [11:0] CoefYB = 12'sd117;
  localparam logic signed [11:0] CoefU  = 12'sd579;
  localparam logic signed [11:0] CoefV  = 12'sd730;
  localparam logic signed [11:0] CoefRV = 12'sd1437;
  localparam logic signed [11:0] CoefGU = 12'sd352;
  localparam logic signed [11:0] CoefGV = 12'sd731;
  localparam logic signed [11:0] CoefBU = 12'sd1812;

  // Largest luma in Q10: 255 * 1024.
  localparam logic [17:0] YMax = 18'd261120;

  // Data leaving the product stage toward the final sum and clamp.
  typedef struct packed {
    logic [31:0]        pixel;
    logic               bypass;
    logic [17:0]        yb;
    logic signed [39:0] rv;
    logic signed [39:0] gu;
    logic signed [39:0] gv;
    logic signed [39:0] bu;
  } plb_prod_t;

endpackage

`default_nettype wire

>>> hdl/plb_luma_pipe.sv
// First three pipeline stages: luma, chroma and offset luma, then the chroma products.
`default_nettype none

module plb_luma_pipe
  import plb_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic [31:0]       pixel_in,
  input  wire logic signed [8:0] bright_add,
  output logic                   out_valid,
  output plb_prod_t              prod
);

  // Stage 1 registers.
  logic        vld1;
  logic [31:0] px1;
  logic        byp1;
  logic [17:0] y1;

  // Stage 2 registers.
  logic               vld2;
  logic [31:0]        px2;
  logic               byp2;
  logic [17:0]        yb2;
  logic signed [28:0] uq2;
  logic signed [28:0] vq2;

  logic [17:0] r18;
  logic [17:0] g18;
  logic [17:0] b18;
  logic [17:0] y_next;
  logic        byp_next;

  logic signed [18:0] du;
  logic signed [18:0] dv;
  logic signed [28:0] du_x;
  logic signed [28:0] dv_x;
  logic signed [28:0] u_next;
  logic signed [28:0] v_next;
  logic signed [19:0] add_q10;
  logic signed [19:0] ysum;
  logic [17:0]        yb_next;

  logic signed [39:0] uq_x;
  logic signed [39:0] vq_x;
  plb_prod_t          prod_next;

  // Stage 1: luma in Q10 and the pass-through decision.
  always_comb begin
    r18      = 18'(pixel_in[23:16]);
    g18      = 18'(pixel_in[15:8]);
    b18      = 18'(pixel_in[7:0]);
    y_next   = r18 * 18'(CoefYR) + g18 * 18'(CoefYG) + b18 * 18'(CoefYB);
    byp_next = (pixel_in[31:24] == 8'd0) || (pixel_in[23:0] == 24'd0);
  end

  // Stage 2: chroma in Q20 and the offset luma, saturated to the 8-bit range.
  always_comb begin
    du      = $signed({1'b0, px1[7:0], 10'b0}) - $signed({1'b0, y1});
    dv      = $signed({1'b0, px1[23:16], 10'b0}) - $signed({1'b0, y1});
    du_x    = 29'(du);
    dv_x    = 29'(dv);
    u_next  = du_x * CoefU;
    v_next  = dv_x * CoefV;
    add_q10 = $signed({bright_add[8], bright_add, 10'b0});
    ysum    = $signed({2'b0, y1}) + add_q10;
    if (ysum < 20'sd0) begin
      yb_next = 18'd0;
    end else if (ysum > $signed({2'b0, YMax})) begin
      yb_next = YMax;
    end else begin
      yb_next = ysum[17:0];
    end
  end

  // Stage 3: products of the back-conversion coefficients with U and V.
  always_comb begin
    uq_x             = 40'(uq2);
    vq_x             = 40'(vq2);
    prod_next.pixel  = px2;
    prod_next.bypass = byp2;
    prod_next.yb     = yb2;
    prod_next.rv     = vq_x * CoefRV;
    prod_next.gu     = uq_x * CoefGU;
    prod_next.gv     = vq_x * CoefGV;
    prod_next.bu     = uq_x * CoefBU;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1      <= 1'b0;
      vld2      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      vld1      <= in_valid;
      vld2      <= vld1;
      out_valid <= vld2;
    end
  end

  always_ff @(posedge clk) begin
    px1  <= pixel_in;
    byp1 <= byp_next;
    y1   <= y_next;
    px2  <= px1;
    byp2 <= byp1;
    yb2  <= yb_next;
    uq2  <= u_next;
    vq2  <= v_next;
    prod <= prod_next;
  end

endmodule

`default_nettype wire

>>> hdl/pixel_luma_brighten.sv
// Top level of the luma brightness adjuster: offset register, final sums and result output.
`default_nettype none

`include "pixel_luma_brighten_assert.svh"

// Takes one 32-bit ARGB pixel per request and returns one pixel on pixel_out,
// marked by a one-cycle done strobe once the pixel has left the last stage.
// A new request can be issued in every cycle; busy is always low, since the
// four-stage pipeline (luma, chroma, products, sum and clamp) keeps one pixel
// in each stage. Results cannot be held off: each appears for exactly one
// cycle and must be taken then. Pixels with zero alpha or black RGB come back
// unchanged. Write bright_add through cfg_we and cfg_wdata only while no
// request is in flight.
module pixel_luma_brighten
  import plb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] pixel_in,
  input  wire logic        cfg_we,
  input  wire logic [8:0]  cfg_wdata,
  output logic             done,
  output logic [31:0]      pixel_out
);

  logic signed [8:0] bright_add;
  logic              req;
  logic              prod_valid;
  plb_prod_t         prod;

  logic signed [41:0] y_q30;
  logic signed [41:0] cr;
  logic signed [41:0] cg;
  logic signed [41:0] cb;
  logic [31:0]        pixel_next;

  // A Q30 channel value becomes an 8-bit channel, truncated and clamped.
  function automatic logic [7:0] to_channel(input logic signed [41:0] q);
    logic [7:0] ch;
    if (q <= 42'sd0) begin
      ch = 8'd0;
    end else if (q[40:38] != 3'd0) begin
      ch = 8'd255;
    end else begin
      ch = q[37:30];
    end
    return ch;
  endfunction

  assign busy = 1'b0;
  assign req  = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      bright_add <= 9'sd0;
    end else if (cfg_we) begin
      bright_add <= $signed(cfg_wdata);
    end
  end

  plb_luma_pipe u_pipe (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (req),
    .pixel_in   (pixel_in),
    .bright_add (bright_add),
    .out_valid  (prod_valid),
    .prod       (prod)
  );

  // Stage 4: each channel summed in Q30, then clamped to 0..255; bypassed pixels pass unchanged.
  always_comb begin
    y_q30 = $signed({4'b0, prod.yb, 20'b0});
    cr    = y_q30 + 42'(prod.rv);
    cg    = y_q30 - 42'(prod.gu) - 42'(prod.gv);
    cb    = y_q30 + 42'(prod.bu);
    if (prod.bypass) begin
      pixel_next = prod.pixel;
    end else begin
      pixel_next = {prod.pixel[31:24], to_channel(cr), to_channel(cg), to_channel(cb)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    pixel_out <= pixel_next;
  end

  // Every result traces back to an earlier request.
  `PLB_ASSERT_IMPL(a_done_from_req, done, $past(req, 4))
  // Alpha always rides through the pipeline untouched.
  `PLB_ASSERT_IMPL(a_alpha_kept, done, pixel_out[31:24] == $past(pixel_in[31:24], 4))
  // Transparent or black pixels come back exactly as they went in.
  `PLB_ASSERT_IMPL(a_bypass_exact,
    done && ($past(pixel_in[31:24], 4) == 8'd0 || $past(pixel_in[23:0], 4) == 24'd0),
    pixel_out == $past(pixel_in, 4))
  // A request always reaches the product stage.
  `PLB_ASSERT_NEXT(a_req_reaches_prod, req && !rst, ##2 prod_valid)

endmodule

`default_nettype wire

>>> tb/sv/tb_pixel_luma_brighten.sv
// Self-checking testbench for the ARGB luma brightness adjuster.
`timescale 1ns / 1ps

module tb_pixel_luma_brighten;

  localparam int CycleLimit   = 100000;
  localparam int DrainCycles  = 8;
  localparam int NumPhases    = 10;
  localparam int RandPerPhase = 190;
  localparam int MaxReports   = 10;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [31:0] pixel_in;
  logic        cfg_we;
  logic [8:0]  cfg_wdata;
  logic        done;
  logic [31:0] pixel_out;

  logic [31:0]       pixel_requests[$];
  logic [31:0]       expected_pixels[$];
  logic signed [8:0] bright_shadow;
  int                idle_pct;
  int                mismatches = 0;
  int                cycles = 0;
  int                offsets[NumPhases] = '{0, 255, -255, -256, 1, -1, 128, -128, 0, 0};
  int                idle_plan[3] = '{0, 58, 7};
  logic [31:0]       directed[20] = '{
    32'h00000000, 32'h00FFFFFF, 32'h00123456, 32'hFF000000, 32'h01000000,
    32'hFFFFFFFF, 32'hFFFF0000, 32'hFF00FF00, 32'hFF0000FF, 32'hFFFFFF00,
    32'hFF00FFFF, 32'hFFFF00FF, 32'h01010101, 32'h80808080, 32'hFF000001,
    32'hFF010000, 32'hFF000100, 32'hAA55AA55, 32'h55AA55AA, 32'hFFFEFEFE
  };

  pixel_luma_brighten DUT (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .pixel_in  (pixel_in),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .done      (done),
    .pixel_out (pixel_out)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Clamps a Q30 channel value to 0..255, truncating toward zero.
  function automatic logic [7:0] channel_of(longint q30);
    longint whole;
    if (q30 <= 0) return 8'd0;
    whole = q30 >>> 30;
    if (whole > 255) return 8'd255;
    return 8'(whole);
  endfunction

  function automatic logic [31:0] predict_brightened(logic [31:0] px, logic signed [8:0] offset);
    longint r, g, b, y, u, v, yb, off;
    r = px[23:16];
    g = px[15:8];
    b = px[7:0];
    off = offset;
    if (px[31:24] == 8'd0 || px[23:0] == 24'd0) return px;
    y = 306 * r + 601 * g + 117 * b;
    u = 579 * (b * 1024 - y);
    v = 730 * (r * 1024 - y);
    yb = y + off * 1024;
    if (yb > 255 * 1024) yb = 255 * 1024;
    if (yb < 0) yb = 0;
    return {px[31:24],
            channel_of(yb * 1048576 + 1437 * v),
            channel_of(yb * 1048576 - 352 * u - 731 * v),
            channel_of(yb * 1048576 + 1812 * u)};
  endfunction

  // Mixes zero alpha, black, extreme channel values and fully random pixels.
  function automatic logic [31:0] rand_pixel();
    logic [31:0] px;
    int k;
    px = $urandom;
    case ($urandom_range(9))
      0: px[31:24] = 8'd0;
      1: px[23:0] = 24'd0;
      2, 3: begin
        for (k = 0; k < 4; k++) begin
          case ($urandom_range(3))
            0: px[k*8 +: 8] = 8'h00;
            1: px[k*8 +: 8] = 8'hFF;
            2: px[k*8 +: 8] = 8'h01;
            default: px[k*8 +: 8] = 8'hFE;
          endcase
        end
      end
      default: ;
    endcase
    return px;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] exp_px, logic [31:0] act_px);
    mismatches++;
    if (mismatches <= MaxReports)
      $display("Mismatch (%s): expected %h, got %h", what, exp_px, act_px);
  endtask

  // Driver: holds a request while busy, otherwise issues the next one unless idling.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      pixel_in <= 32'h0;
      bright_shadow = 9'sd0;
    end else begin
      if (cfg_we) bright_shadow = cfg_wdata;
      if (start && !busy) expected_pixels.push_back(predict_brightened(pixel_in, bright_shadow));
      if (start && busy) begin
        // Request not taken yet; keep it on the ports.
      end else if (pixel_requests.size() != 0 && $urandom_range(99) >= idle_pct) begin
        start <= 1'b1;
        pixel_in <= pixel_requests.pop_front();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every done strobe must match the oldest outstanding prediction.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_pixels.size() == 0) report_mismatch("unexpected result", 32'h0, pixel_out);
      else begin
        logic [31:0] exp_px;
        exp_px = expected_pixels.pop_front();
        if (pixel_out !== exp_px) report_mismatch("pixel_out", exp_px, pixel_out);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic wait_idle();
    while (pixel_requests.size() != 0 || start || expected_pixels.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_bright(int value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= 9'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int p;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = 9'h0;
    idle_pct = 0;
    offsets[8] = int'($urandom_range(510)) - 255;
    offsets[9] = int'($urandom_range(510)) - 255;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // The first phase runs with the reset offset of zero.
    for (p = 0; p < NumPhases; p++) begin
      if (p > 0) begin
        wait_idle();
        write_bright(offsets[p]);
      end
      @(negedge clk);
      idle_pct = idle_plan[p % 3];
      if (p == 0) foreach (directed[k]) pixel_requests.push_back(directed[k]);
      repeat (RandPerPhase) pixel_requests.push_back(rand_pixel());
    end
    wait_idle();

    if (expected_pixels.size() != 0) report_mismatch("missing result", expected_pixels[0], 32'h0);
    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

>>> sim.f
+incdir+hdl
hdl/plb_pkg.sv
hdl/plb_luma_pipe.sv
hdl/pixel_luma_brighten.sv
tb/sv/tb_pixel_luma_brighten.sv
